// File: hw/rtl/odtt_pkg.sv
// Shared types and constants of the one-shot deadline timer table.
// No dependencies; every other file of the block imports this package.
package odtt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned HANDLE_W        = 16;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_IDLE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_PAST = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

// File: hw/rtl/odtt_if.sv
// Valid/ready channel interfaces for the timer table: request and result.
// Depends on odtt_pkg.
interface odtt_in_if import odtt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [TIME_W-1:0]   now;
  logic [TIME_W-1:0]   deadline;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output op, output now, output deadline, output handle,
                  input ready);
  modport sink   (input valid, input op, input now, input deadline, input handle,
                  output ready);
endinterface

interface odtt_out_if import odtt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [1:0]          status;
  logic [HANDLE_W-1:0] fired_handle;
  logic                last;

  modport source (output valid, output kind, output status, output fired_handle,
                  output last, input ready);
  modport sink   (input valid, input kind, input status, input fired_handle,
                  input last, output ready);
endinterface

// File: hw/rtl/odtt_mem.sv
// Timer entry store: one write port, one read port, registered read data.
// Depends on odtt_pkg for the entry layout.
module odtt_mem import odtt_pkg::*; #(
  parameter int unsigned Depth = TABLE_DEPTH_DEF,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/odtt_ctrl.sv
// Sequencer of the timer table: register/append, expiry scan with in-place
// compaction, pending-result holding and the output register. Uses odtt_pkg
// and the channel interfaces; drives the entry store in odtt_mem.
module odtt_ctrl import odtt_pkg::*; #(
  parameter int unsigned TableDepth = TABLE_DEPTH_DEF,
  parameter int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  parameter int unsigned CountW     = $clog2(TableDepth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  odtt_in_if.sink           in_i,
  odtt_out_if.source        out_o,
  output logic [AddrW-1:0]  mem_raddr_o,
  output logic              mem_we_o,
  output logic [AddrW-1:0]  mem_waddr_o,
  output entry_t            mem_wdata_o,
  input  entry_t            mem_rdata_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  localparam logic [CountW-1:0] CountFull = CountW'(TableDepth);

  logic [1:0]          state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [AddrW-1:0]    rd_q, rd_d;
  logic [CountW-1:0]   wr_q, wr_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic                pend_valid_q, pend_valid_d;
  kind_e               pend_kind_q, pend_kind_d;
  status_e             pend_status_q, pend_status_d;
  logic [HANDLE_W-1:0] pend_handle_q, pend_handle_d;

  logic                out_valid_q;
  kind_e               out_kind_q;
  status_e             out_status_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic                out_last_q;

  logic                emit, emit_ok, emit_last;
  kind_e               emit_kind;
  status_e             emit_status;
  logic [HANDLE_W-1:0] emit_handle;
  logic                expired, stall, last_entry;

  assign emit_ok    = !out_valid_q || out_o.ready;
  assign expired    = mem_rdata_i.deadline < now_q;
  assign stall      = expired && pend_valid_q && !emit_ok;
  assign last_entry = (CountW'(rd_q) + 1'b1) == count_q;
  assign in_i.ready = (state_q == StIdle);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rd_d          = rd_q;
    wr_d          = wr_q;
    now_d         = now_q;
    pend_valid_d  = pend_valid_q;
    pend_kind_d   = pend_kind_q;
    pend_status_d = pend_status_q;
    pend_handle_d = pend_handle_q;
    emit          = 1'b0;
    emit_kind     = KIND_FIRED;
    emit_status   = ST_OK;
    emit_handle   = pend_handle_q;
    emit_last     = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = count_q[AddrW-1:0];
    mem_wdata_o   = '{deadline: in_i.deadline, handle: in_i.handle};
    mem_raddr_o   = '0;

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          if (in_i.op == OP_RUN) begin
            now_d        = in_i.now;
            rd_d         = '0;
            wr_d         = '0;
            pend_valid_d = 1'b0;
            state_d      = (count_q == '0) ? StFlush : StScan;
          end else begin
            pend_valid_d  = 1'b1;
            pend_kind_d   = KIND_STATUS;
            pend_handle_d = '0;
            if (in_i.deadline < in_i.now) begin
              pend_status_d = ST_PAST;
            end else if (count_q == CountFull) begin
              pend_status_d = ST_FULL;
            end else begin
              pend_status_d = ST_OK;
              mem_we_o      = 1'b1;
              count_d       = count_q + 1'b1;
            end
            state_d = StFlush;
          end
        end
      end
      StScan: begin
        // Read data belongs to rd_q. Writes land at wr_q <= rd_q, so they never
        // touch an entry still to be read: no forwarding is needed.
        mem_raddr_o = stall ? rd_q : rd_q + 1'b1;
        if (!stall) begin
          if (expired) begin
            // the previous fired handle goes out; this one waits, it may be last
            emit          = pend_valid_q;
            pend_valid_d  = 1'b1;
            pend_kind_d   = KIND_FIRED;
            pend_status_d = ST_OK;
            pend_handle_d = mem_rdata_i.handle;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = wr_q[AddrW-1:0];
            mem_wdata_o = mem_rdata_i;
            wr_d        = wr_q + 1'b1;
          end
          rd_d = rd_q + 1'b1;
          if (last_entry) begin
            count_d = expired ? wr_q : wr_q + 1'b1;
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (pend_valid_q) begin
            emit_kind   = pend_kind_q;
            emit_status = pend_status_q;
            emit_handle = pend_handle_q;
          end else begin
            emit_kind   = KIND_IDLE;
            emit_status = ST_OK;
            emit_handle = '0;
          end
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q          <= rd_d;
    wr_q          <= wr_d;
    now_q         <= now_d;
    pend_kind_q   <= pend_kind_d;
    pend_status_q <= pend_status_d;
    pend_handle_q <= pend_handle_d;
    if (emit) begin
      out_kind_q   <= emit_kind;
      out_status_q <= emit_status;
      out_handle_q <= emit_handle;
      out_last_q   <= emit_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.status       = out_status_q;
  assign out_o.fired_handle = out_handle_q;
  assign out_o.last         = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountFull)
    else $error("entry count beyond table depth");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && mem_we_o) |-> (wr_q <= CountW'(rd_q)))
    else $error("compaction write overtook the scan read");

  a_run_no_growth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush && $past(state_q) == StScan) |-> (count_q <= $past(count_q)))
    else $error("scan grew the table");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_valid_q)
    else $error("result left pending in idle");

endmodule

// File: hw/rtl/one_shot_deadline_timer_table.sv
// One-shot deadline timer table. Holds up to TableDepth timers (32-bit
// deadline, 16-bit handle) in insertion order in a single-port-read entry
// memory. A register beat is accepted, then its status result is issued.
// A run beat scans the stored entries through the memory read port, one
// entry per cycle unless output back-pressure stalls it, expiring and
// compacting in place; fired handles come out in stored order with last on
// the final one, or a single "nothing expired" result. A new beat is
// accepted once the previous one has been handed to the output register,
// even if that result is still waiting; back-pressure on the output can
// stall a scan. The entry memory needs no clearing pass after reset.
module one_shot_deadline_timer_table import odtt_pkg::*; #(
  parameter int unsigned TableDepth = TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  odtt_in_if.sink     in_i,
  odtt_out_if.source  out_o
);

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  logic [AddrW-1:0] mem_raddr;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;

  odtt_ctrl #(
    .TableDepth (TableDepth),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  odtt_mem #(
    .Depth (TableDepth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: test/tb_one_shot_deadline_timer_table.sv
// Self-checking bench for the one-shot deadline timer table: register/run beats,
// expiry in stored order, compaction, past/full refusals, random stalls both sides.
// Depends on odtt_pkg, odtt_if and one_shot_deadline_timer_table.
module tb_one_shot_deadline_timer_table;
  import odtt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                op;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   deadline;
    logic [HANDLE_W-1:0] handle;
  } timer_req_t;

  typedef struct packed {
    kind_e               kind;
    status_e             status;
    logic [HANDLE_W-1:0] fired_handle;
    logic                last;
  } timer_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #10 clk_i = ~clk_i;

  odtt_in_if  req_if ();
  odtt_out_if rsp_if ();

  one_shot_deadline_timer_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  timer_req_t          req_q[$];
  timer_req_t          req_on_bus;
  timer_out_t          outcome_q[$];
  logic [TIME_W-1:0]   armed_deadline[$];
  logic [HANDLE_W-1:0] armed_handle[$];

  int   reqs_total    = 0;
  int   reqs_accepted = 0;
  int   fail_count    = 0;
  int   send_gap      = 0;
  int   take_gap      = 0;
  logic tail_calm;

  task automatic queue_timer_req(input logic op, input logic [TIME_W-1:0] now,
                                 input logic [TIME_W-1:0] deadline,
                                 input logic [HANDLE_W-1:0] handle);
    timer_req_t r;
    r.op       = op;
    r.now      = now;
    r.deadline = deadline;
    r.handle   = handle;
    req_q.push_back(r);
    reqs_total++;
  endtask

  // Shadow table: appends on register, expires and compacts on run.
  function automatic void advance_timer_table(timer_req_t r);
    timer_out_t          o;
    logic [TIME_W-1:0]   kept_dl[$];
    logic [HANDLE_W-1:0] kept_h[$];
    int                  due;
    int                  sent;
    due          = 0;
    sent         = 0;
    o.status       = ST_OK;
    o.fired_handle = '0;
    o.last         = 1'b1;
    if (r.op == OP_REGISTER) begin
      o.kind = KIND_STATUS;
      if (r.deadline < r.now) begin
        o.status = ST_PAST;
      end else if (armed_deadline.size() >= TABLE_DEPTH_DEF) begin
        o.status = ST_FULL;
      end else begin
        armed_deadline.push_back(r.deadline);
        armed_handle.push_back(r.handle);
      end
      outcome_q.push_back(o);
    end else begin
      foreach (armed_deadline[i]) begin
        if (armed_deadline[i] < r.now) due++;
      end
      foreach (armed_deadline[i]) begin
        if (armed_deadline[i] < r.now) begin
          sent++;
          o.kind         = KIND_FIRED;
          o.fired_handle = armed_handle[i];
          o.last         = (sent == due);
          outcome_q.push_back(o);
        end else begin
          kept_dl.push_back(armed_deadline[i]);
          kept_h.push_back(armed_handle[i]);
        end
      end
      armed_deadline = kept_dl;
      armed_handle   = kept_h;
      if (due == 0) begin
        o.kind         = KIND_IDLE;
        o.fired_handle = '0;
        o.last         = 1'b1;
        outcome_q.push_back(o);
      end
    end
  endfunction

  task automatic log_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.op       <= OP_REGISTER;
      req_if.now      <= '0;
      req_if.deadline <= '0;
      req_if.handle   <= '0;
      tail_calm       <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        advance_timer_table(req_on_bus);
        reqs_accepted++;
      end
      tail_calm <= (req_q.size() < 50);
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (!tail_calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 14);
          req_if.valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          req_on_bus = req_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.op       <= req_on_bus.op;
          req_if.now      <= req_on_bus.now;
          req_if.deadline <= req_on_bus.deadline;
          req_if.handle   <= req_on_bus.handle;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    timer_out_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (outcome_q.size() == 0) begin
          log_mismatch($sformatf("unexpected beat kind %0d status %0d handle %h last %b",
                                 rsp_if.kind, rsp_if.status, rsp_if.fired_handle,
                                 rsp_if.last));
        end else begin
          want = outcome_q.pop_front();
          if (rsp_if.kind !== want.kind || rsp_if.status !== want.status ||
              rsp_if.fired_handle !== want.fired_handle || rsp_if.last !== want.last) begin
            log_mismatch($sformatf({"expected kind %s status %s handle %h last %b, ",
                                    "got kind %0d status %0d handle %h last %b"},
                                   want.kind.name(), want.status.name(),
                                   want.fired_handle, want.last, rsp_if.kind,
                                   rsp_if.status, rsp_if.fired_handle, rsp_if.last));
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        rsp_if.ready <= 1'b0;
      end else if (!tail_calm && $urandom_range(0, 9) == 0) begin
        take_gap = $urandom_range(0, 14);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] mark;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] dl;
    int                burst;

    rst_ni <= 1'b0;

    // Directed: empty run, equal/past deadlines, fill to full, refusals, expiry edges
    queue_timer_req(OP_RUN,      32'd0,        32'd0,        16'h0000);
    queue_timer_req(OP_REGISTER, 32'd0,        32'd0,        16'h0000);
    queue_timer_req(OP_REGISTER, 32'hFFFFFFFF, 32'hFFFFFFFE, 16'h1234);
    queue_timer_req(OP_REGISTER, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    for (int i = 0; i < 14; i++) begin
      queue_timer_req(OP_REGISTER, 32'd1000, 32'd1000 + 32'(10 * i), 16'hA500 + 16'(i));
    end
    queue_timer_req(OP_REGISTER, 32'd1000,       32'd5000,       16'hBEEF);
    queue_timer_req(OP_REGISTER, 32'd1000,       32'd999,        16'hDEAD);
    queue_timer_req(OP_RUN,      32'd0,          32'hFFFFFFFF,   16'hFFFF);
    queue_timer_req(OP_RUN,      32'd1000,       32'd0,          16'h0000);
    // deadline 1050 equals now here and must survive
    queue_timer_req(OP_RUN,      32'd1050,       32'd0,          16'h0000);
    queue_timer_req(OP_RUN,      32'hFFFFFFFF,   32'd0,          16'h0000);
    queue_timer_req(OP_RUN,      32'hFFFFFFFF,   32'd0,          16'h0000);

    // Random: bursts of registers near a moving time base, each closed by a run
    mark = $urandom();
    while (reqs_total < 430) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        t = mark + $urandom_range(0, 5);
        case ($urandom_range(0, 9))
          0:       dl = t - $urandom_range(1, 8);
          1:       dl = $urandom();
          default: dl = t + $urandom_range(0, 40);
        endcase
        queue_timer_req(OP_REGISTER, t, dl, 16'($urandom()));
      end
      if ($urandom_range(0, 9) == 0) t = $urandom();
      else t = mark + $urandom_range(0, 45);
      queue_timer_req(OP_RUN, t, 32'($urandom()), 16'($urandom()));
      if ($urandom_range(0, 7) == 0) mark = $urandom();
      else mark = mark + $urandom_range(0, 30);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (reqs_accepted < reqs_total) @(negedge clk_i);
    while (outcome_q.size() > 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    if (outcome_q.size() > 0) log_mismatch("results still outstanding at end of run");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
